// ===== rtl/core/gdat_pkg.sv =====
// Shared types and constants for the disk geometry address translator.
`timescale 1ns / 1ps
`default_nettype none

package gdat_pkg;

    localparam int LinW    = 28;
    localparam int CylW    = 12;
    localparam int HeadW   = 8;
    localparam int BlkW    = 8;
    localparam int PerCylW = HeadW + BlkW;
    localparam int HdrW    = 32;
    localparam int DataW   = 32;
    localparam int AddrW   = 4;

    localparam logic [CylW-1:0]    CYL_RST     = 12'd815;
    localparam logic [HeadW-1:0]   HEAD_RST    = 8'd19;
    localparam logic [BlkW-1:0]    BLK_RST     = 8'd17;
    localparam logic [PerCylW-1:0] PER_CYL_RST = 16'd323;

    // commands
    localparam logic CMD_TO_CHS = 1'b0;
    localparam logic CMD_TO_LIN = 1'b1;

    // register indexes (paddr[3:2])
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_CYL  = 2'd0;
    localparam t_reg_idx REG_HEAD = 2'd1;
    localparam t_reg_idx REG_BLK  = 2'd2;

    typedef enum logic [1:0] {
        NEXT_TRACK = 2'd0,
        NEXT_HEAD  = 2'd1,
        NEXT_CYL   = 2'd2,
        NEXT_END   = 2'd3
    } t_next;

    typedef struct packed {
        logic [CylW-1:0]    cyl;
        logic [HeadW-1:0]   head;
        logic [BlkW-1:0]    blk;
        logic [PerCylW-1:0] per_cyl;
    } t_geom;

    // request fields carried alongside the divider
    typedef struct packed {
        logic              cmd;
        logic [LinW-1:0]   lin;
        logic [CylW-1:0]   cyl;
        logic [HeadW-1:0]  head;
        logic [BlkW-1:0]   blk;
    } t_side;

    typedef struct packed {
        t_side           side;
        logic [LinW-1:0] quo;
    } t_side2;

endpackage

`default_nettype wire

// ===== rtl/core/gdat_req_if.sv =====
// Request channel: command and address or coordinates.
`timescale 1ns / 1ps
`default_nettype none

interface gdat_req_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [gdat_pkg::LinW-1:0]   linear_address;
    logic [gdat_pkg::CylW-1:0]   cylinder_in;
    logic [gdat_pkg::HeadW-1:0]  head_in;
    logic [gdat_pkg::BlkW-1:0]   block_in;

    modport source (output valid, cmd, linear_address, cylinder_in, head_in, block_in,
                    input ready);
    modport sink   (input valid, cmd, linear_address, cylinder_in, head_in, block_in,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gdat_rsp_if.sv =====
// Response channel: translated address, coordinates and sector header.
`timescale 1ns / 1ps
`default_nettype none

interface gdat_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [gdat_pkg::LinW-1:0]   linear_out;
    logic [gdat_pkg::CylW-1:0]   cylinder_out;
    logic [gdat_pkg::HeadW-1:0]  head_out;
    logic [gdat_pkg::BlkW-1:0]   block_out;
    logic [gdat_pkg::HdrW-1:0]   header_word;
    logic [1:0]                  next_code;
    logic                        out_of_range;

    modport source (output valid, linear_out, cylinder_out, head_out, block_out,
                    header_word, next_code, out_of_range, input ready);
    modport sink   (input valid, linear_out, cylinder_out, head_out, block_out,
                    header_word, next_code, out_of_range, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gdat_div_cell.sv =====
// One restoring-division cell: resolves one quotient bit and passes the word on.
`timescale 1ns / 1ps
`default_nettype none

module gdat_div_cell #(
    parameter int RemW  = 16,
    parameter int NumW  = 28,
    parameter int SideW = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_take,
    input  wire logic [RemW-1:0]  i_rem,
    input  wire logic [NumW-1:0]  i_num,
    input  wire logic [RemW-1:0]  i_divisor,
    input  wire logic [SideW-1:0] i_side,
    output logic                  o_valid,
    input  wire logic             i_take_next,
    output logic [RemW-1:0]       o_rem,
    output logic [NumW-1:0]       o_num,
    output logic [SideW-1:0]      o_side
);

    logic             r_valid;
    logic [RemW-1:0]  r_rem;
    logic [NumW-1:0]  r_num;
    logic [SideW-1:0] r_side;
    logic [RemW:0]    w_trial;
    logic [RemW:0]    w_diff;
    logic             w_ge;

    // bring down the next dividend bit; quotient bits shift in at the bottom
    assign w_trial = {i_rem, i_num[NumW-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign w_ge    = w_trial >= {1'b0, i_divisor};

    assign o_take = !r_valid || i_take_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_rem  <= w_ge ? w_diff[RemW-1:0] : w_trial[RemW-1:0];
            r_num  <= {i_num[NumW-2:0], w_ge};
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== rtl/core/gdat_finish.sv =====
// Tail stages: coordinate-to-linear multiply, range check, next code and header.
`timescale 1ns / 1ps
`default_nettype none

module gdat_finish (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_take,
    input  wire gdat_pkg::t_side2              i_side,
    input  wire logic [gdat_pkg::HeadW-1:0]    i_head_q,
    input  wire logic [gdat_pkg::BlkW-1:0]     i_blk_r,
    input  wire gdat_pkg::t_geom               i_geom,
    gdat_rsp_if.source                         o_rsp
);

    localparam int ProdW = gdat_pkg::CylW + gdat_pkg::HeadW;

    // stage A
    logic                           r_a_valid;
    logic                           r_a_cmd;
    logic [gdat_pkg::LinW-1:0]      r_a_lin;
    logic [gdat_pkg::LinW-1:0]      r_a_cyl;
    logic [gdat_pkg::HeadW-1:0]     r_a_head;
    logic [gdat_pkg::BlkW-1:0]      r_a_blk;
    logic [ProdW-1:0]               r_a_prod;
    logic                           r_a_bad;
    logic [gdat_pkg::LinW-1:0]      n_a_cyl;
    logic [gdat_pkg::HeadW-1:0]     n_a_head;
    logic [gdat_pkg::BlkW-1:0]      n_a_blk;
    logic [ProdW-1:0]               n_a_prod;
    logic                           n_a_bad;
    logic                           w_no_div;
    logic                           w_take_b;

    // stage B (output word)
    logic                           r_b_valid;
    logic [gdat_pkg::LinW-1:0]      r_b_lin;
    logic [gdat_pkg::CylW-1:0]      r_b_cyl;
    logic [gdat_pkg::HeadW-1:0]     r_b_head;
    logic [gdat_pkg::BlkW-1:0]      r_b_blk;
    gdat_pkg::t_next                r_b_code;
    logic                           r_b_bad;
    logic [gdat_pkg::LinW-1:0]      n_b_lin;
    gdat_pkg::t_next                n_b_code;
    logic [gdat_pkg::LinW-1:0]      w_mul;

    assign w_no_div = i_geom.per_cyl == '0;
    assign w_take_b = !r_b_valid || o_rsp.ready;
    assign o_take   = !r_a_valid || w_take_b;

    always_comb begin
        if (i_side.side.cmd == gdat_pkg::CMD_TO_CHS) begin
            n_a_cyl  = w_no_div ? '0 : i_side.quo;
            n_a_head = w_no_div ? '0 : i_head_q;
            n_a_blk  = w_no_div ? '0 : i_blk_r;
            n_a_bad  = w_no_div || (i_side.quo >= gdat_pkg::LinW'(i_geom.cyl));
        end else begin
            n_a_cyl  = gdat_pkg::LinW'(i_side.side.cyl);
            n_a_head = i_side.side.head;
            n_a_blk  = i_side.side.blk;
            n_a_bad  = (i_side.side.cyl >= i_geom.cyl) || (i_side.side.head >= i_geom.head)
                       || (i_side.side.blk >= i_geom.blk);
        end
        n_a_prod = ProdW'(ProdW'(i_side.side.cyl) * ProdW'(i_geom.head))
                   + ProdW'(i_side.side.head);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_take) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_a_cmd  <= i_side.side.cmd;
            r_a_lin  <= i_side.side.lin;
            r_a_cyl  <= n_a_cyl;
            r_a_head <= n_a_head;
            r_a_blk  <= n_a_blk;
            r_a_prod <= n_a_prod;
            r_a_bad  <= n_a_bad;
        end
    end

    assign w_mul = gdat_pkg::LinW'(gdat_pkg::LinW'(r_a_prod) * gdat_pkg::LinW'(i_geom.blk))
                   + gdat_pkg::LinW'(r_a_blk);

    always_comb begin
        if (r_a_cmd == gdat_pkg::CMD_TO_CHS) begin
            n_b_lin = r_a_lin;
        end else begin
            n_b_lin = r_a_bad ? '0 : w_mul;
        end
        // use the full cylinder so anything past the last one reads as end of pack
        if (({1'b0, r_a_blk} + 9'd1) < {1'b0, i_geom.blk}) begin
            n_b_code = gdat_pkg::NEXT_TRACK;
        end else if (({1'b0, r_a_head} + 9'd1) < {1'b0, i_geom.head}) begin
            n_b_code = gdat_pkg::NEXT_HEAD;
        end else if (({1'b0, r_a_cyl} + 29'd1) < 29'(i_geom.cyl)) begin
            n_b_code = gdat_pkg::NEXT_CYL;
        end else begin
            n_b_code = gdat_pkg::NEXT_END;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_take_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_b && r_a_valid) begin
            r_b_lin  <= n_b_lin;
            r_b_cyl  <= r_a_cyl[gdat_pkg::CylW-1:0];
            r_b_head <= r_a_head;
            r_b_blk  <= r_a_blk;
            r_b_code <= n_b_code;
            r_b_bad  <= r_a_bad;
        end
    end

    assign o_rsp.valid        = r_b_valid;
    assign o_rsp.linear_out   = r_b_lin;
    assign o_rsp.cylinder_out = r_b_cyl;
    assign o_rsp.head_out     = r_b_head;
    assign o_rsp.block_out    = r_b_blk;
    assign o_rsp.header_word  = {r_b_code, 2'b00, r_b_cyl, r_b_head, r_b_blk};
    assign o_rsp.next_code    = r_b_code;
    assign o_rsp.out_of_range = r_b_bad;

endmodule

`default_nettype wire

// ===== rtl/core/disk_geometry_address_translator_unit.sv =====
// Top level of the disk geometry address translator.
// Converts a linear block number to cylinder/head/block (command 0) or back (command 1),
// and builds the sector header word with its next-block code and a range flag. A new
// request word is taken every cycle unless a response-side stall pushes back; each result
// passes 28 division cells for linear/(heads*blocks), 8 cells for the remainder/blocks,
// then a multiply stage and the output register. The division chains resolve one bit
// per cell. Stalls on the response side fill empty stages first, then push back
// to the request side. Geometry registers sit on the APB port at byte offsets 0, 4, 8
// and must be written only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module disk_geometry_address_translator_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [gdat_pkg::AddrW-1:0]     paddr,
    input  wire logic [gdat_pkg::DataW-1:0]     pwdata,
    output logic [gdat_pkg::DataW-1:0]          prdata,
    output logic                                pready,
    gdat_req_if.sink                            i_req,
    gdat_rsp_if.source                          o_rsp
);

    localparam int Div1N = gdat_pkg::LinW;
    localparam int Div2N = gdat_pkg::BlkW;
    localparam int RemW  = gdat_pkg::PerCylW;

    gdat_pkg::t_geom  r_geom;
    gdat_pkg::t_reg_idx w_idx;
    logic             w_wr;

    logic                      w_v1    [0:Div1N];
    logic                      w_take1 [0:Div1N];
    logic [RemW-1:0]           w_rem1  [0:Div1N];
    logic [gdat_pkg::LinW-1:0] w_num1  [0:Div1N];
    gdat_pkg::t_side           w_side1 [0:Div1N];

    logic                      w_v2    [0:Div2N];
    logic                      w_take2 [0:Div2N];
    logic [gdat_pkg::BlkW-1:0] w_rem2  [0:Div2N];
    logic [gdat_pkg::BlkW-1:0] w_num2  [0:Div2N];
    gdat_pkg::t_side2          w_side2 [0:Div2N];

    // configuration port
    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.cyl     <= gdat_pkg::CYL_RST;
            r_geom.head    <= gdat_pkg::HEAD_RST;
            r_geom.blk     <= gdat_pkg::BLK_RST;
            r_geom.per_cyl <= gdat_pkg::PER_CYL_RST;
        end else if (w_wr) begin
            case (w_idx)
                gdat_pkg::REG_CYL: begin
                    r_geom.cyl <= pwdata[gdat_pkg::CylW-1:0];
                end
                gdat_pkg::REG_HEAD: begin
                    r_geom.head    <= pwdata[gdat_pkg::HeadW-1:0];
                    r_geom.per_cyl <= RemW'(pwdata[gdat_pkg::HeadW-1:0]) * RemW'(r_geom.blk);
                end
                gdat_pkg::REG_BLK: begin
                    r_geom.blk     <= pwdata[gdat_pkg::BlkW-1:0];
                    r_geom.per_cyl <= RemW'(r_geom.head) * RemW'(pwdata[gdat_pkg::BlkW-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            gdat_pkg::REG_CYL:  prdata = gdat_pkg::DataW'(r_geom.cyl);
            gdat_pkg::REG_HEAD: prdata = gdat_pkg::DataW'(r_geom.head);
            gdat_pkg::REG_BLK:  prdata = gdat_pkg::DataW'(r_geom.blk);
            default:            prdata = '0;
        endcase
    end

    // first chain: linear / (heads * blocks)
    assign w_v1[0]        = i_req.valid;
    assign i_req.ready    = w_take1[0];
    assign w_rem1[0]      = '0;
    assign w_num1[0]      = i_req.linear_address;
    assign w_side1[0].cmd  = i_req.cmd;
    assign w_side1[0].lin  = i_req.linear_address;
    assign w_side1[0].cyl  = i_req.cylinder_in;
    assign w_side1[0].head = i_req.head_in;
    assign w_side1[0].blk  = i_req.block_in;

    for (genvar k = 0; k < Div1N; k++) begin : g_div1
        gdat_div_cell #(
            .RemW  (RemW),
            .NumW  (gdat_pkg::LinW),
            .SideW ($bits(gdat_pkg::t_side))
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_valid     (w_v1[k]),
            .o_take      (w_take1[k]),
            .i_rem       (w_rem1[k]),
            .i_num       (w_num1[k]),
            .i_divisor   (r_geom.per_cyl),
            .i_side      (w_side1[k]),
            .o_valid     (w_v1[k+1]),
            .i_take_next (w_take1[k+1]),
            .o_rem       (w_rem1[k+1]),
            .o_num       (w_num1[k+1]),
            .o_side      (w_side1[k+1])
        );
    end

    // second chain: remainder / blocks; the head quotient fits in 8 bits,
    // so the upper remainder byte starts as the partial remainder
    assign w_v2[0]           = w_v1[Div1N];
    assign w_take1[Div1N]    = w_take2[0];
    assign w_rem2[0]         = w_rem1[Div1N][RemW-1:gdat_pkg::BlkW];
    assign w_num2[0]         = w_rem1[Div1N][gdat_pkg::BlkW-1:0];
    assign w_side2[0].side   = w_side1[Div1N];
    assign w_side2[0].quo    = w_num1[Div1N];

    for (genvar k = 0; k < Div2N; k++) begin : g_div2
        gdat_div_cell #(
            .RemW  (gdat_pkg::BlkW),
            .NumW  (gdat_pkg::BlkW),
            .SideW ($bits(gdat_pkg::t_side2))
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_valid     (w_v2[k]),
            .o_take      (w_take2[k]),
            .i_rem       (w_rem2[k]),
            .i_num       (w_num2[k]),
            .i_divisor   (r_geom.blk),
            .i_side      (w_side2[k]),
            .o_valid     (w_v2[k+1]),
            .i_take_next (w_take2[k+1]),
            .o_rem       (w_rem2[k+1]),
            .o_num       (w_num2[k+1]),
            .o_side      (w_side2[k+1])
        );
    end

    gdat_finish u_finish (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_v2[Div2N]),
        .o_take   (w_take2[Div2N]),
        .i_side   (w_side2[Div2N]),
        .i_head_q (w_num2[Div2N]),
        .i_blk_r  (w_rem2[Div2N]),
        .i_geom   (r_geom),
        .o_rsp    (o_rsp)
    );

endmodule

`default_nettype wire
